### design/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
`timescale 1ns / 1ps

package spq_pkg;

    localparam int SPQ_DEPTH = 16;
    localparam int ITEM_W    = 16;
    localparam int KEY_W     = 8;
    localparam int FILL_W    = 5;
    localparam int OP_W      = 2;

    localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [ITEM_W-1:0] item_in;
        logic [KEY_W-1:0]  key;
    } cmd_t;

    typedef struct packed {
        logic              ok;
        logic [ITEM_W-1:0] item_out;
        logic [FILL_W-1:0] fill;
        logic              is_empty;
        logic              is_full;
        logic [ITEM_W-1:0] head_item;
        logic [ITEM_W-1:0] tail_item;
    } res_t;

    typedef struct packed {
        logic [ITEM_W-1:0] item;
        logic [KEY_W-1:0]  key;
    } entry_t;

endpackage

### design/spq_ram.sv
// Entry store: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module spq_ram #(
    parameter int DEPTH = spq_pkg::SPQ_DEPTH
) (
    input  logic                     clk,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output spq_pkg::entry_t          rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  spq_pkg::entry_t          wr_data
);
    import spq_pkg::*;

    entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

### design/spq_ctrl.sv
// Sequencer: key scan, entry shifting, head removal and result assembly.
`timescale 1ns / 1ps

module spq_ctrl #(
    parameter int DEPTH = spq_pkg::SPQ_DEPTH
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  spq_pkg::cmd_t            cmd,
    output logic                     busy,
    output logic                     done,
    output spq_pkg::res_t            res,
    output logic [$clog2(DEPTH)-1:0] rd_addr,
    input  spq_pkg::entry_t          rd_data,
    output logic                     wr_en,
    output logic [$clog2(DEPTH)-1:0] wr_addr,
    output spq_pkg::entry_t          wr_data
);
    import spq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_SCAN  = 8'b0000_0010,
        ST_SHIFT = 8'b0000_0100,
        ST_PLACE = 8'b0000_1000,
        ST_DEQ   = 8'b0001_0000,
        ST_RPT_H = 8'b0010_0000,
        ST_RPT_T = 8'b0100_0000,
        ST_FIN   = 8'b1000_0000
    } state_t;

    state_t            state_reg, state_next;
    logic [CW-1:0]     occ_reg, occ_next;
    logic [CW-1:0]     src_reg, src_next;
    logic [CW-1:0]     pos_reg, pos_next;
    logic [AW-1:0]     rr_reg, rr_next;
    logic              pend_reg, pend_next;
    logic              ok_reg, ok_next;
    logic              done_reg, done_next;
    logic [ITEM_W-1:0] item_reg, item_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [ITEM_W-1:0] removed_reg, removed_next;
    logic [ITEM_W-1:0] head_reg, head_next;
    res_t              res_reg, res_next;
    logic              nonempty;

    assign busy     = (state_reg != ST_IDLE);
    assign done     = done_reg;
    assign res      = res_reg;
    assign nonempty = (occ_reg != '0);

    always_comb
    begin
        state_next   = state_reg;
        occ_next     = occ_reg;
        src_next     = src_reg;
        pos_next     = pos_reg;
        rr_next      = rr_reg;
        pend_next    = pend_reg;
        ok_next      = ok_reg;
        done_next    = 1'b0;
        item_next    = item_reg;
        key_next     = key_reg;
        removed_next = removed_reg;
        head_next    = head_reg;
        res_next     = res_reg;
        rd_addr      = '0;
        wr_en        = 1'b0;
        wr_addr      = '0;
        wr_data      = '{item: item_reg, key: key_reg};

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    item_next    = cmd.item_in;
                    key_next     = cmd.key;
                    ok_next      = 1'b0;
                    removed_next = '0;
                    pend_next    = 1'b0;
                    if ((cmd.op == OP_APPEND || cmd.op == OP_INSERT) &&
                        occ_reg < CW'(DEPTH))
                    begin
                        ok_next = 1'b1;
                        if (cmd.op == OP_INSERT && nonempty)
                        begin
                            src_next   = '0;
                            state_next = ST_SCAN;
                        end
                        else
                        begin
                            pos_next   = occ_reg;
                            src_next   = occ_reg;
                            state_next = ST_SHIFT;
                        end
                    end
                    else if (cmd.op == OP_REMOVE && nonempty)
                    begin
                        ok_next    = 1'b1;
                        src_next   = '0;
                        state_next = ST_DEQ;
                    end
                    else
                    begin
                        state_next = ST_RPT_H;
                    end
                end
            end

            // one read issued per cycle, compare on the data of the previous one
            ST_SCAN:
            begin
                rd_addr = AW'(src_reg);
                if (pend_reg && key_reg > rd_data.key)
                begin
                    pos_next   = CW'(src_reg - 1'b1);
                    src_next   = occ_reg;
                    pend_next  = 1'b0;
                    state_next = ST_SHIFT;
                end
                else if (src_reg == occ_reg)
                begin
                    pos_next   = occ_reg;
                    src_next   = occ_reg;
                    pend_next  = 1'b0;
                    state_next = ST_SHIFT;
                end
                else
                begin
                    src_next  = CW'(src_reg + 1'b1);
                    pend_next = 1'b1;
                end
            end

            // move entries pos..occ-1 one place back, tail first
            ST_SHIFT:
            begin
                if (pend_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = rr_reg;
                    wr_data = rd_data;
                end
                if (src_reg > pos_reg)
                begin
                    rd_addr   = AW'(src_reg - 1'b1);
                    rr_next   = AW'(src_reg);
                    src_next  = CW'(src_reg - 1'b1);
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next  = 1'b0;
                    state_next = ST_PLACE;
                end
            end

            ST_PLACE:
            begin
                wr_en      = 1'b1;
                wr_addr    = AW'(pos_reg);
                occ_next   = CW'(occ_reg + 1'b1);
                state_next = ST_RPT_H;
            end

            // entry 0 is captured, entries 1..occ-1 move one place forward
            ST_DEQ:
            begin
                if (pend_reg)
                begin
                    if (rr_reg == '0)
                    begin
                        removed_next = rd_data.item;
                    end
                    else
                    begin
                        wr_en   = 1'b1;
                        wr_addr = AW'(rr_reg - 1'b1);
                        wr_data = rd_data;
                    end
                end
                if (src_reg < occ_reg)
                begin
                    rd_addr   = AW'(src_reg);
                    rr_next   = AW'(src_reg);
                    src_next  = CW'(src_reg + 1'b1);
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next  = 1'b0;
                    occ_next   = CW'(occ_reg - 1'b1);
                    state_next = ST_RPT_H;
                end
            end

            ST_RPT_H:
            begin
                rd_addr    = '0;
                state_next = ST_RPT_T;
            end

            ST_RPT_T:
            begin
                rd_addr    = AW'(occ_reg - 1'b1);
                head_next  = rd_data.item;
                state_next = ST_FIN;
            end

            ST_FIN:
            begin
                res_next.ok        = ok_reg;
                res_next.item_out  = removed_reg;
                res_next.fill      = FILL_W'(occ_reg);
                res_next.is_empty  = !nonempty;
                res_next.is_full   = (occ_reg == CW'(DEPTH));
                res_next.head_item = nonempty ? head_reg : '0;
                res_next.tail_item = nonempty ? rd_data.item : '0;
                done_next          = 1'b1;
                state_next         = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            occ_reg   <= '0;
            src_reg   <= '0;
            pos_reg   <= '0;
            rr_reg    <= '0;
            pend_reg  <= 1'b0;
            ok_reg    <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            occ_reg   <= occ_next;
            src_reg   <= src_next;
            pos_reg   <= pos_next;
            rr_reg    <= rr_next;
            pend_reg  <= pend_next;
            ok_reg    <= ok_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg    <= item_next;
        key_reg     <= key_next;
        removed_reg <= removed_next;
        head_reg    <= head_next;
        res_reg     <= res_next;
    end

endmodule

### design/sorted_priority_queue.sv
// Sorted priority queue top level: sequencer plus entry store.
//
// Usage:
//   A request is taken when start is high and busy is low. cmd carries op
//   (append at tail, insert by key, remove head), the item handle and its key.
//   Insert by key places the item before the first entry with a smaller key,
//   so larger keys leave first and equal keys keep arrival order.
//   busy stays high while the request runs; nothing else is taken meanwhile.
//   The result appears on res for exactly one cycle with done high, and must
//   be captured then: there is no way to hold it off.
//   Time from the accepting edge to done grows with the entries held for
//   insert by key and remove; append and a failed request do not depend on it.
//   Cost is set by the single read port of the store: the key scan reads one
//   entry a cycle, and each moved entry needs one read and one write.
//   One request at a time; a new one may start in the cycle done is shown.
//   Reset empties the queue and clears busy and done; store contents are
//   not cleared and are never used before being written.
`timescale 1ns / 1ps

module sorted_priority_queue #(
    parameter int DEPTH = spq_pkg::SPQ_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  spq_pkg::cmd_t cmd,
    output logic          busy,
    output logic          done,
    output spq_pkg::res_t res
);
    import spq_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic          wr_en;
    entry_t        rd_data;
    entry_t        wr_data;

    spq_ctrl #(
        .DEPTH(DEPTH)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .cmd     (cmd),
        .busy    (busy),
        .done    (done),
        .res     (res),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    spq_ram #(
        .DEPTH(DEPTH)
    ) u_ram (
        .clk     (clk),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while busy");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted request did not raise busy");

    a_empty_full: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(res.is_empty && res.is_full))
        else $error("queue reported empty and full");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && res.is_empty |-> res.head_item == '0 && res.tail_item == '0)
        else $error("empty queue reported a head or tail item");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !res.ok |-> res.item_out == '0)
        else $error("failed request returned an item");

endmodule
